// ===== rtl/core/kbms_pkg.sv =====
`timescale 1ns / 1ps

package kbms_pkg;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_DATA   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_NO_ROOM   = 3'd2,
		ST_FULL      = 3'd3,
		ST_MISS      = 3'd4,
		ST_HIT       = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_HEAD_RD,
		S_HEAD_WAIT,
		S_ENT_WAIT,
		S_ENT_CHECK,
		S_DECIDE,
		S_WORD_RD,
		S_WORD_WAIT,
		S_WORD_OUT,
		S_RESULT
	} fsm_t;

	localparam int SIZE_BITS = 7;

endpackage

// ===== rtl/core/keyed_block_memo_store_core.sv =====
`timescale 1ns / 1ps

// Keyed block memo store. Blocks of 64-bit words are stored under a key of four
// shell indices and three permutation flags; the bucket is the low
// HASH_BITS_PER_SHELL bits of each shell index (shell_a most significant) and
// each bucket heads a newest-first chain kept in synchronous memories. A lookup
// reads the bucket head, then walks the chain entry by entry (entry read, key
// check); a hit then streams the block word by word (memory read, read latency,
// output register), a word being loaded only once the previous one has been
// taken, with last on the final word; a miss gives one result with status miss.
// A store header walks the chain for a duplicate the same way, checks size, word
// room against store_capacity (clamped to STORE_WORDS) and table room, links the
// entry and returns one result. Store data transactions are taken from idle and
// give no result. Clear all sweeps every bucket (2**(4*HASH_BITS_PER_SHELL)
// buckets, 256 by default) while no transaction is accepted; the same sweep runs
// after reset. Every item is handled to completion before the next is taken.
module keyed_block_memo_store_core
	import kbms_pkg::*;
#(
	parameter int STORE_WORDS         = 65536,
	parameter int MAX_ENTRIES         = 512,
	parameter int MAX_BLOCK           = 64,
	parameter int SHELL_BITS          = 10,
	parameter int HASH_BITS_PER_SHELL = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [16:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [SHELL_BITS-1:0] shell_a,
	input  logic [SHELL_BITS-1:0] shell_b,
	input  logic [SHELL_BITS-1:0] shell_c,
	input  logic [SHELL_BITS-1:0] shell_d,
	input  logic                  perm_first_pair,
	input  logic                  perm_second_pair,
	input  logic                  perm_pair_swap,
	input  logic [6:0]            block_words,
	input  logic [63:0]           word_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [63:0]           word_out,
	output logic                  last
);

	localparam int BKT_BITS = 4 * HASH_BITS_PER_SHELL;
	localparam int BUCKETS  = 1 << BKT_BITS;
	localparam int EW       = $clog2(MAX_ENTRIES);
	localparam int LW       = $clog2(MAX_ENTRIES + 1);  // link: entry + 1, 0 empty
	localparam int AW       = $clog2(STORE_WORDS);
	localparam int UW       = $clog2(STORE_WORDS + 1);
	localparam int KW       = 3 * SHELL_BITS + SHELL_BITS + 3;

	// memories
	logic [LW-1:0] head_mem [BUCKETS];
	logic [KW-1:0] key_mem  [MAX_ENTRIES];
	logic [AW+SIZE_BITS+LW-1:0] place_mem [MAX_ENTRIES];
	logic [63:0]   word_mem [STORE_WORDS];

	fsm_t state_q, state_d;

	logic [16:0]     cap_q;
	logic [UW-1:0]   used_q;
	logic [LW-1:0]   count_q;
	logic [AW:0]     wptr_q;
	logic [6:0]      pending_q;
	logic            discard_q;

	logic            is_header_q;
	logic [KW-1:0]   key_q;
	logic [BKT_BITS-1:0] bkt_q;
	logic [6:0]      bw_q;
	logic [LW-1:0]   link_q;
	logic [LW-1:0]   head_q;
	logic [LW-1:0]   hit_q;
	logic [AW-1:0]   off_q;
	logic [6:0]      n_q;
	logic [6:0]      k_q;
	logic [BKT_BITS-1:0] clr_q;

	logic [LW-1:0]   head_rd_q;
	logic [KW-1:0]   key_rd_q;
	logic [AW+SIZE_BITS+LW-1:0] place_rd_q;
	logic [63:0]     word_rd_q;

	logic [2:0]      status_q;
	logic [63:0]     word_q;
	logic            last_q;
	logic            ovalid_q;

	logic            acc;
	logic [KW-1:0]   key_in;
	logic [BKT_BITS-1:0] bkt_in;
	logic [UW:0]     need;
	logic [UW:0]     cap_eff;
	logic [2:0]      hdr_status;
	logic [6:0]      pl_size;
	logic [6:0]      n_eff;

	assign in_ready = (state_q == S_IDLE) && !ovalid_q;
	assign acc      = in_valid && in_ready;
	assign key_in   = {perm_pair_swap, perm_second_pair, perm_first_pair,
		shell_d, shell_c, shell_b, shell_a};
	assign bkt_in   = {shell_a[HASH_BITS_PER_SHELL-1:0], shell_b[HASH_BITS_PER_SHELL-1:0],
		shell_c[HASH_BITS_PER_SHELL-1:0], shell_d[HASH_BITS_PER_SHELL-1:0]};

	assign out_valid = ovalid_q;
	assign status    = status_q;
	assign word_out  = word_q;
	assign last      = last_q;

	assign need    = (UW+1)'(used_q) + (UW+1)'(bw_q);
	assign cap_eff = (cap_q > 17'(STORE_WORDS)) ? (UW+1)'(STORE_WORDS) : (UW+1)'(cap_q);
	assign pl_size = place_rd_q[AW +: SIZE_BITS];
	assign n_eff   = (pl_size > 7'(MAX_BLOCK)) ? 7'(MAX_BLOCK) : pl_size;

	always_comb begin
		if (hit_q != '0)
			hdr_status = ST_DUPLICATE;
		else if (bw_q == '0 || bw_q > 7'(MAX_BLOCK))
			hdr_status = ST_NO_ROOM;
		else if (need > cap_eff)
			hdr_status = ST_NO_ROOM;
		else if (count_q >= LW'(MAX_ENTRIES))
			hdr_status = ST_FULL;
		else
			hdr_status = ST_STORED;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (mode_t'(mode))
						MODE_LOOKUP, MODE_HEADER: state_d = S_HEAD_RD;
						MODE_CLEAR:               state_d = S_CLEAR;
						default:                  state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR:     if (clr_q == BKT_BITS'(BUCKETS - 1)) state_d = S_IDLE;
			S_HEAD_RD:   state_d = S_HEAD_WAIT;
			S_HEAD_WAIT: state_d = (head_rd_q == '0) ? S_DECIDE : S_ENT_WAIT;
			S_ENT_WAIT:  state_d = S_ENT_CHECK;
			S_ENT_CHECK: begin
				if (key_rd_q == key_q)
					state_d = S_DECIDE;
				else if (place_rd_q[AW+SIZE_BITS +: LW] == '0)
					state_d = S_DECIDE;
				else
					state_d = S_ENT_WAIT;
			end
			S_DECIDE: begin
				if (!is_header_q && hit_q != '0 && n_eff != '0)
					state_d = S_WORD_RD;
				else if (!is_header_q && hit_q != '0)
					state_d = S_IDLE;
				else
					state_d = S_RESULT;
			end
			S_WORD_RD:   state_d = S_WORD_WAIT;
			S_WORD_WAIT: state_d = S_WORD_OUT;
			S_WORD_OUT: begin
				if (!ovalid_q)
					state_d = (k_q + 7'd1 == n_q) ? S_IDLE : S_WORD_RD;
			end
			S_RESULT:    if (!ovalid_q) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			head_mem[clr_q] <= '0;
		else if (state_q == S_DECIDE && is_header_q && hdr_status == ST_STORED)
			head_mem[bkt_q] <= count_q + LW'(1);
		head_rd_q <= head_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && is_header_q && hdr_status == ST_STORED) begin
			key_mem[count_q[EW-1:0]]   <= key_q;
			place_mem[count_q[EW-1:0]] <= {head_q, bw_q, used_q[AW-1:0]};
		end
		key_rd_q   <= key_mem[link_q[EW-1:0] - EW'(1)];
		place_rd_q <= place_mem[link_q[EW-1:0] - EW'(1)];
	end

	always_ff @(posedge clk) begin
		if (acc && mode_t'(mode) == MODE_DATA && pending_q != '0 && !discard_q
			&& !wptr_q[AW])
			word_mem[wptr_q[AW-1:0]] <= word_in;
		word_rd_q <= word_mem[off_q + AW'(k_q)];
	end

	// control and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= 17'd65536;
			used_q    <= '0;
			count_q   <= '0;
			wptr_q    <= '0;
			pending_q <= '0;
			discard_q <= 1'b0;
			clr_q     <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (ovalid_q && out_ready)
				ovalid_q <= 1'b0;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + BKT_BITS'(1);
			if (acc && mode_t'(mode) == MODE_CLEAR) begin
				used_q    <= '0;
				count_q   <= '0;
				wptr_q    <= '0;
				pending_q <= '0;
				discard_q <= 1'b0;
				clr_q     <= '0;
			end
			if (acc && mode_t'(mode) == MODE_DATA && pending_q != '0) begin
				pending_q <= pending_q - 7'd1;
				if (!discard_q)
					wptr_q <= wptr_q + (AW+1)'(1);
			end
			if (state_q == S_DECIDE && is_header_q) begin
				pending_q <= bw_q;
				if (hdr_status == ST_STORED) begin
					count_q   <= count_q + LW'(1);
					wptr_q    <= (AW+1)'(used_q);
					used_q    <= used_q + UW'(bw_q);
					discard_q <= 1'b0;
				end else begin
					discard_q <= 1'b1;
				end
			end
			if (state_q == S_DECIDE && (is_header_q || hit_q == '0)) begin
				// result for header or miss is loaded in S_DECIDE and presented from S_RESULT
			end
			if (state_q == S_RESULT && !ovalid_q)
				ovalid_q <= 1'b1;
			if (state_q == S_WORD_OUT && !ovalid_q)
				ovalid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			is_header_q <= (mode_t'(mode) == MODE_HEADER);
			key_q       <= key_in;
			bkt_q       <= bkt_in;
			bw_q        <= block_words;
			hit_q       <= '0;
		end
		if (state_q == S_HEAD_WAIT) begin
			link_q <= head_rd_q;
			head_q <= head_rd_q;
		end
		if (state_q == S_ENT_CHECK) begin
			if (key_rd_q == key_q) begin
				hit_q <= link_q;
				off_q <= place_rd_q[AW-1:0];
				n_q   <= n_eff;
			end else begin
				link_q <= place_rd_q[AW+SIZE_BITS +: LW];
			end
		end
		if (state_q == S_DECIDE) begin
			k_q      <= '0;
			status_q <= is_header_q ? hdr_status : ST_MISS;
			word_q   <= '0;
			last_q   <= 1'b1;
		end
		// load the next word only once the previous transaction has left
		if (state_q == S_WORD_OUT && !ovalid_q) begin
			status_q <= ST_HIT;
			word_q   <= word_rd_q;
			last_q   <= (k_q + 7'd1 == n_q);
			k_q      <= k_q + 7'd1;
		end
	end

endmodule
